### rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types, constants and header byte selection for the message chunker.
// ----------------------------------------------------------------------------
package rmc_pkg;

   localparam logic [23:0] BIG_TS      = 24'hffffff;
   localparam logic [1:0]  T3_FMT      = 2'b11;
   localparam logic [1:0]  T0_FMT      = 2'b00;
   localparam logic [4:0]  T0_LEN      = 5'd12;
   localparam logic [4:0]  T0_EXT_LEN  = 5'd16;
   localparam logic [4:0]  T3_LEN      = 5'd1;
   localparam logic [4:0]  NO_HDR_LEN  = 5'd0;
   localparam logic [15:0] CHUNK_RESET = 16'd128;

   typedef enum logic [1:0] {
      HDR_NONE   = 2'd0,
      HDR_T0     = 2'd1,
      HDR_T0_EXT = 2'd2,
      HDR_T3     = 2'd3
   } hdr_kind_type;

   typedef struct packed {
      logic        mode;
      logic [5:0]  channel;
      logic [31:0] timestamp;
      logic [7:0]  type_id;
      logic [31:0] stream_id;
      logic [23:0] msg_len;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       last_of_run;
      logic       end_of_message;
   } rsp_item_type;

   // one body byte plus the header that must precede it
   typedef struct packed {
      hdr_kind_type kind;
      logic [5:0]   channel;
      logic [31:0]  timestamp;
      logic [7:0]   type_id;
      logic [31:0]  stream_id;
      logic [23:0]  msg_len;
      logic [7:0]   data_byte;
      logic         eom;
   } job_type;

   function automatic logic [4:0] hdr_len(input hdr_kind_type kind);
      logic [4:0] len;
      case (kind)
         HDR_T0:     len = T0_LEN;
         HDR_T0_EXT: len = T0_EXT_LEN;
         HDR_T3:     len = T3_LEN;
         default:    len = NO_HDR_LEN;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hdr_byte(input job_type job, input logic [4:0] idx);
      logic [23:0] ts24;
      logic [7:0]  b;
      ts24 = (job.kind == HDR_T0_EXT) ? BIG_TS : job.timestamp[23:0];
      if (job.kind == HDR_T3) begin
         b = {T3_FMT, job.channel};
      end else begin
         case (idx)
            5'd0:    b = {T0_FMT, job.channel};
            5'd1:    b = ts24[23:16];
            5'd2:    b = ts24[15:8];
            5'd3:    b = ts24[7:0];
            5'd4:    b = job.msg_len[23:16];
            5'd5:    b = job.msg_len[15:8];
            5'd6:    b = job.msg_len[7:0];
            5'd7:    b = job.type_id;
            5'd8:    b = job.stream_id[7:0];
            5'd9:    b = job.stream_id[15:8];
            5'd10:   b = job.stream_id[23:16];
            5'd11:   b = job.stream_id[31:24];
            5'd12:   b = job.timestamp[31:24];
            5'd13:   b = job.timestamp[23:16];
            5'd14:   b = job.timestamp[15:8];
            5'd15:   b = job.timestamp[7:0];
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

### rtl/rmc_chan_if.sv
// ----------------------------------------------------------------------------
// rmc_chan_if
// Valid/ready channel carrying one item of a given type.
// ----------------------------------------------------------------------------
interface rmc_chan_if #(
   parameter type item_type = logic
);
   logic     valid;
   logic     ready;
   item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rtmp_message_chunker.sv
// ----------------------------------------------------------------------------
// rtmp_message_chunker
// Splits messages into RTMP chunks, one byte per cycle unless output stalls.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    mode, channel, timestamp, type_id,
//                                stream_id, msg_len, data_byte
//  rsp_chan  out  valid/ready    out_byte, is_header, last_of_run,
//                                end_of_message
//  csr_*     in   write enable   chunk size (16 bits)
//
// One output byte per cycle while not stalled: a body byte follows a 12- or
// 16-byte type-0 header, a 1-byte type-3 header or none, sent by the byte
// sequencer. Start items and dropped bytes are taken and give no output.
// Input is taken while the job queue has room; output stalls hold the
// sequencer only. Reset clears all control state; chunk size resets to 128.
// ----------------------------------------------------------------------------
module rtmp_message_chunker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   rmc_chan_if.sink    req_chan,
   rmc_chan_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic             push, pop, full, head_valid;
   rmc_pkg::job_type push_job, head_job;

   rmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   rmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   rmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### rtl/rmc_front.sv
// ----------------------------------------------------------------------------
// rmc_front
// Accepts items, tracks the open message and classifies each body byte
// by the header it needs.
// ----------------------------------------------------------------------------
module rmc_front (
   input  logic                  clock,
   input  logic                  reset,
   rmc_chan_if.sink              req_chan,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  logic                  queue_full,
   output logic                  push,
   output rmc_pkg::job_type      push_job
);

   logic [15:0] chunk_size_ff, chunk_size_in;
   logic [5:0]  channel_ff, channel_in;
   logic [31:0] timestamp_ff, timestamp_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] stream_ff, stream_in;
   logic [23:0] size_ff, size_in;
   logic [23:0] sent_ff, sent_in;
   logic [15:0] fill_ff, fill_in;
   logic        open_ff, open_in;

   logic                  accept;
   logic [15:0]           limit;
   logic [23:0]           sent_next;
   logic                  eom;
   rmc_pkg::hdr_kind_type kind;
   rmc_pkg::req_item_type item;

   assign item           = req_chan.payload;
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign limit          = (chunk_size_ff == 16'd0) ? 16'd1 : chunk_size_ff;
   assign sent_next      = sent_ff + 24'd1;
   assign eom            = (sent_next >= size_ff);

   always_comb begin
      if (sent_ff == 24'd0) begin
         kind = (timestamp_ff >= {8'h00, rmc_pkg::BIG_TS}) ? rmc_pkg::HDR_T0_EXT
                                                            : rmc_pkg::HDR_T0;
      end else if (fill_ff >= limit) begin
         kind = rmc_pkg::HDR_T3;
      end else begin
         kind = rmc_pkg::HDR_NONE;
      end
   end

   always_comb begin
      chunk_size_in = csr_wr_en ? csr_wr_data : chunk_size_ff;
      channel_in    = channel_ff;
      timestamp_in  = timestamp_ff;
      type_in       = type_ff;
      stream_in     = stream_ff;
      size_in       = size_ff;
      sent_in       = sent_ff;
      fill_in       = fill_ff;
      open_in       = open_ff;
      push          = 1'b0;
      if (accept) begin
         if (!item.mode) begin
            channel_in   = item.channel;
            timestamp_in = item.timestamp;
            type_in      = item.type_id;
            stream_in    = item.stream_id;
            size_in      = item.msg_len;
            sent_in      = 24'd0;
            fill_in      = 16'd0;
            open_in      = (item.msg_len != 24'd0);
         end else if (open_ff) begin
            push    = 1'b1;
            sent_in = sent_next;
            fill_in = ((kind == rmc_pkg::HDR_NONE) ? fill_ff : 16'd0) + 16'd1;
            open_in = !eom;
         end
      end
   end

   always_comb begin
      push_job.kind      = kind;
      push_job.channel   = channel_ff;
      push_job.timestamp = timestamp_ff;
      push_job.type_id   = type_ff;
      push_job.stream_id = stream_ff;
      push_job.msg_len   = size_ff;
      push_job.data_byte = item.data_byte;
      push_job.eom       = eom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= rmc_pkg::CHUNK_RESET;
         channel_ff    <= '0;
         timestamp_ff  <= '0;
         type_ff       <= '0;
         stream_ff     <= '0;
         size_ff       <= '0;
         sent_ff       <= '0;
         fill_ff       <= '0;
         open_ff       <= 1'b0;
      end else begin
         chunk_size_ff <= chunk_size_in;
         channel_ff    <= channel_in;
         timestamp_ff  <= timestamp_in;
         type_ff       <= type_in;
         stream_ff     <= stream_in;
         size_ff       <= size_in;
         sent_ff       <= sent_in;
         fill_ff       <= fill_in;
         open_ff       <= open_in;
      end
   end

endmodule

### rtl/rmc_queue.sv
// ----------------------------------------------------------------------------
// rmc_queue
// Short job queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module rmc_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output rmc_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rmc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/rmc_back.sv
// ----------------------------------------------------------------------------
// rmc_back
// Byte sequencer: walks the header of the head job, then its body byte,
// into a registered output stage.
// ----------------------------------------------------------------------------
module rmc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  rmc_pkg::job_type head_job,
   output logic             pop,
   rmc_chan_if.source       rsp_chan
);

   logic                  valid_ff, valid_in;
   rmc_pkg::rsp_item_type out_ff, out_in;
   logic [4:0]            idx_ff, idx_in;
   logic                  can_load;
   logic                  at_body;

   assign can_load = !valid_ff || rsp_chan.ready;
   assign at_body  = (idx_ff == rmc_pkg::hdr_len(head_job.kind));
   assign pop      = can_load && head_valid && at_body;

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      idx_in   = idx_ff;
      if (can_load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (at_body) begin
               out_in.out_byte       = head_job.data_byte;
               out_in.is_header      = 1'b0;
               out_in.last_of_run    = 1'b1;
               out_in.end_of_message = head_job.eom;
               idx_in                = 5'd0;
            end else begin
               out_in.out_byte       = rmc_pkg::hdr_byte(head_job, idx_ff);
               out_in.is_header      = 1'b1;
               out_in.last_of_run    = 1'b0;
               out_in.end_of_message = 1'b0;
               idx_in                = idx_ff + 5'd1;
            end
         end
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### bench/rtmp_message_chunker_tb.sv
// ----------------------------------------------------------------------------
// rtmp_message_chunker_tb
// Self-checking bench for the message chunker. Start and body-byte items go
// in through a valid/ready driver with random gaps. A monitor with random
// back-pressure compares every output byte, in order, against a predictor
// that tracks the open message, the chunk fill and the chunk size. A short
// directed set covers the header forms, empty and abandoned messages and
// dropped bytes. Random messages then run under several chunk sizes,
// including 0, 1 and 65535, with messages left open across size changes
// and one long output stall.
// ----------------------------------------------------------------------------
module rtmp_message_chunker_tb;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 6;
   localparam int NUM_PHASES     = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   rmc_chan_if #(.item_type(rmc_pkg::req_item_type)) req_chan ();
   rmc_chan_if #(.item_type(rmc_pkg::rsp_item_type)) rsp_chan ();

   rtmp_message_chunker uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [15:0] chunk_size = rmc_pkg::CHUNK_RESET;
   logic [5:0]  msg_channel = '0;
   logic [31:0] msg_timestamp = '0;
   logic [7:0]  msg_type_id = '0;
   logic [31:0] msg_stream = '0;
   logic [23:0] msg_size = '0;
   logic [23:0] body_sent = '0;
   logic [15:0] chunk_fill = '0;
   bit          msg_open = 1'b0;

   rmc_pkg::req_item_type items_to_send[$];
   rmc_pkg::rsp_item_type chunk_bytes_due[$];

   bit offering = 1'b0;
   bit send_steady = 1'b0;
   bit take_steady = 1'b1;
   int send_gap = 0;
   int take_gap = 0;
   int hold_left = 0;
   int stall_requests = 0;
   int stalls_served = 0;
   int failures = 0;
   int cycle_count = 0;
   int queued_items = 0;
   int accepted_items = 0;
   int checked_bytes = 0;
   int t3_headers = 0;
   int ext_headers = 0;
   int settings_used = 1;

   initial forever #5 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rtmp_message_chunker regression: fail");
      $finish;
   end

   function automatic int draw_gap(inout bit steady);
      if ($urandom_range(0, 15) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic rmc_pkg::rsp_item_type make_byte(input logic [7:0] b,
                                                       input logic hdr,
                                                       input logic eom);
      rmc_pkg::rsp_item_type r;
      r.out_byte       = b;
      r.is_header      = hdr;
      r.last_of_run    = 1'b0;
      r.end_of_message = eom;
      return r;
   endfunction

   function automatic void predict_chunk_bytes(input rmc_pkg::req_item_type it);
      rmc_pkg::rsp_item_type run[$];
      logic [7:0]   hdr[16];
      logic [23:0]  ts24;
      logic [15:0]  limit;
      bit           big_ts;
      int           hdr_count;
      if (it.mode == 1'b0) begin
         msg_channel   = it.channel;
         msg_timestamp = it.timestamp;
         msg_type_id   = it.type_id;
         msg_stream    = it.stream_id;
         msg_size      = it.msg_len;
         body_sent     = '0;
         chunk_fill    = '0;
         msg_open      = (it.msg_len != 24'd0);
         return;
      end
      if (!msg_open) return;
      limit = (chunk_size == 16'd0) ? 16'd1 : chunk_size;
      hdr_count = 0;
      if (body_sent == 24'd0) begin
         big_ts  = (msg_timestamp >= {8'h00, rmc_pkg::BIG_TS});
         ts24    = big_ts ? rmc_pkg::BIG_TS : msg_timestamp[23:0];
         hdr[0]  = {rmc_pkg::T0_FMT, msg_channel};
         hdr[1]  = ts24[23:16];
         hdr[2]  = ts24[15:8];
         hdr[3]  = ts24[7:0];
         hdr[4]  = msg_size[23:16];
         hdr[5]  = msg_size[15:8];
         hdr[6]  = msg_size[7:0];
         hdr[7]  = msg_type_id;
         hdr[8]  = msg_stream[7:0];
         hdr[9]  = msg_stream[15:8];
         hdr[10] = msg_stream[23:16];
         hdr[11] = msg_stream[31:24];
         hdr[12] = msg_timestamp[31:24];
         hdr[13] = msg_timestamp[23:16];
         hdr[14] = msg_timestamp[15:8];
         hdr[15] = msg_timestamp[7:0];
         hdr_count = big_ts ? int'(rmc_pkg::T0_EXT_LEN) : int'(rmc_pkg::T0_LEN);
         if (big_ts) ext_headers++;
         chunk_fill = '0;
      end else if (chunk_fill >= limit) begin
         hdr[0] = {rmc_pkg::T3_FMT, msg_channel};
         hdr_count = int'(rmc_pkg::T3_LEN);
         t3_headers++;
         chunk_fill = '0;
      end
      for (int i = 0; i < hdr_count; i++) run.push_back(make_byte(hdr[i], 1'b1, 1'b0));
      body_sent  = body_sent + 24'd1;
      chunk_fill = chunk_fill + 16'd1;
      run.push_back(make_byte(it.data_byte, 1'b0, body_sent >= msg_size));
      if (body_sent >= msg_size) msg_open = 1'b0;
      run[$].last_of_run = 1'b1;
      foreach (run[i]) chunk_bytes_due.push_back(run[i]);
   endfunction

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_chunk_bytes(req_chan.payload);
            accepted_items++;
            offering = 1'b0;
            send_gap = draw_gap(send_steady);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (items_to_send.size() != 0) begin
               req_chan.payload <= items_to_send.pop_front();
               offering = 1'b1;
            end
         end
         req_chan.valid <= offering;
      end
   end

   // output monitor
   always @(posedge clock) begin
      rmc_pkg::rsp_item_type got;
      rmc_pkg::rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            checked_bytes++;
            if (chunk_bytes_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected output: byte %02h hdr %b last %b eom %b", $time,
                        got.out_byte, got.is_header, got.last_of_run, got.end_of_message);
            end else begin
               want = chunk_bytes_due.pop_front();
               if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
                   got.last_of_run !== want.last_of_run ||
                   got.end_of_message !== want.end_of_message) begin
                  failures++;
                  $display("%0t: mismatch: expected %02h/%b/%b/%b, actual %02h/%b/%b/%b",
                           $time, want.out_byte, want.is_header, want.last_of_run,
                           want.end_of_message, got.out_byte, got.is_header,
                           got.last_of_run, got.end_of_message);
               end
            end
            take_gap = draw_gap(take_steady);
         end
         if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic rmc_pkg::req_item_type random_item();
      rmc_pkg::req_item_type it;
      it.mode      = 1'b1;
      it.channel   = 6'($urandom_range(0, 63));
      it.timestamp = $urandom();
      it.type_id   = 8'($urandom_range(0, 255));
      it.stream_id = $urandom();
      it.msg_len   = 24'($urandom_range(0, 24'hffffff));
      it.data_byte = 8'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic logic [31:0] random_ts();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 32'h00fffffe);
         1:       return $urandom_range(32'h00fffffd, 32'h01000001);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_start(input logic [5:0] ch, input logic [31:0] ts,
                              input logic [7:0] ty, input logic [31:0] sid,
                              input logic [23:0] size);
      rmc_pkg::req_item_type it;
      it = random_item();
      it.mode      = 1'b0;
      it.channel   = ch;
      it.timestamp = ts;
      it.type_id   = ty;
      it.stream_id = sid;
      it.msg_len   = size;
      items_to_send.push_back(it);
      queued_items++;
   endtask

   // body bytes; strays are not counted as stimulus
   task automatic queue_body(input int n, input bit counted);
      for (int i = 0; i < n; i++) begin
         items_to_send.push_back(random_item());
         if (counted) queued_items++;
      end
   endtask

   task automatic queue_message(input logic [23:0] size, input int n);
      queue_start(6'($urandom_range(0, 63)), random_ts(), 8'($urandom_range(0, 255)),
                  $urandom(), size);
      queue_body(n, 1'b1);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (items_to_send.size() != 0 || offering || chunk_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_chunk_size(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      chunk_size = value;
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] chunk_settings[NUM_PHASES];
      logic [15:0] setting;
      int          target;
      int          kind;
      int          size;
      int          carry_left;
      chunk_settings = '{16'd1, 16'd0, 16'd3, 16'hffff, 16'd2, rmc_pkg::CHUNK_RESET};
      carry_left = 0;
      do @(negedge clock); while (reset);

      queue_body(1, 1'b0);
      queue_start(6'd0, 32'd0, 8'd0, 32'd0, 24'd1);
      queue_body(1, 1'b1);
      queue_body(1, 1'b0);
      queue_start(6'd63, 32'hffffffff, 8'hff, 32'hffffffff, 24'd2);
      queue_body(2, 1'b1);
      queue_start(6'd1, 32'h00ffffff, 8'h14, 32'd1, 24'd1);
      queue_body(1, 1'b1);
      queue_start(6'd2, 32'h00fffffe, 8'h08, 32'h01000000, 24'd0);
      queue_body(1, 1'b0);
      queue_start(6'd3, 32'h00fffffe, 8'h09, 32'h12345678, 24'd3);
      queue_body(1, 1'b1);
      queue_start(6'd4, 32'h00abcdef, 8'h12, 32'h00000080, 24'd1);
      queue_body(1, 1'b1);
      queue_start(6'd5, 32'd1000, 8'h09, 32'd1, 24'hffffff);
      queue_body(2, 1'b1);
      queue_start(6'd62, 32'd0, 8'h12, 32'd0, 24'h800000);
      queue_body(1, 1'b1);
      queue_start(6'd6, 32'd7, 8'd8, 32'd9, 24'd1);
      queue_body(1, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         setting = (p == 4) ? 16'($urandom_range(2, 9)) : chunk_settings[p];
         write_chunk_size(setting);
         queue_body(carry_left, 1'b1);
         target = queued_items + PHASE_ITEMS;
         while (queued_items < target) begin
            kind = $urandom_range(0, 15);
            if (kind < 11) begin
               size = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40)
                                                  : $urandom_range(1, 20);
               queue_message(24'(size), size);
            end else if (kind < 13) begin
               queue_message(24'($urandom_range(1, 24'hffffff)), $urandom_range(0, 5));
            end else if (kind == 13) begin
               queue_message(24'd0, 0);
               queue_body($urandom_range(0, 2), 1'b0);
            end else begin
               size = $urandom_range(1, 12);
               queue_message(24'(size), size);
               queue_body($urandom_range(1, 3), 1'b0);
            end
         end
         // leave a message open so the next chunk size applies mid-message
         if (p < NUM_PHASES - 1) begin
            size = $urandom_range(4, 10);
            queue_message(24'(size), size / 2);
            carry_left = size - size / 2;
         end
         if (p == 2) stall_requests++;
      end
      settle();

      $display("covered %0d items (%0d accepted incl. dropped), %0d output bytes checked",
               queued_items, accepted_items, checked_bytes);
      $display("%0d type-3 and %0d extended-timestamp headers over %0d chunk sizes",
               t3_headers, ext_headers, settings_used);
      if (failures == 0) begin
         $display("rtmp_message_chunker regression: pass");
      end else begin
         $display("rtmp_message_chunker regression: fail");
      end
      $finish;
   end

endmodule
